// File: rtl/core/multi_channel_linear_fade_engine_top_macros.svh
// Assertion macros for the fade engine.
`ifndef MULTI_CHANNEL_LINEAR_FADE_ENGINE_TOP_MACROS_SVH
`define MULTI_CHANNEL_LINEAR_FADE_ENGINE_TOP_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define MCLF_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Check an implication in the next cycle.
`define MCLF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// File: rtl/core/mclf_pkg.sv
// Package with types and constants of the fade engine.
package mclf_pkg;
    localparam int unsigned LEVEL_W = 32;
    localparam int unsigned VALUE_W = 24;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned VALUE_FIELDS = 4;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_LOAD   = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_PAUSE  = 3'd3,
        ACT_RESUME = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_RUN,
        ST_LOAD_WR,
        ST_SCAN,
        ST_RD,
        ST_RD_WAIT,
        ST_STEP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// File: rtl/core/multi_channel_linear_fade_engine_top.sv
// Top level of the multi-channel linear fade engine.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  request | in        | i_valid / o_stall | action, job, channel, values, ticks
//  result  | out       | o_valid / i_stall | slot, count, value0..3, flags
//
// Stop, pause, resume and unknown codes pass through the write state; load waits on
// the 34-step divider that forms the rate. A tick walks every slot, stepping each
// running job's channels through the single level RAM read port and the shared step
// adder; a stalled result holds the walk until taken.
// Reset clears the active and paused flags at once; level stores need none.
// o_stall is high whenever a request is in work.
module multi_channel_linear_fade_engine_top #(
    parameter int JOB_SLOTS    = 16,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_job,
    input  logic [1:0]  i_channel,
    input  logic signed [23:0] i_start_value,
    input  logic signed [23:0] i_target_value,
    input  logic [15:0] i_duration_ticks,
    input  logic        i_last_channel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_job_slot,
    output logic [2:0]  o_channel_count,
    output logic signed [23:0] o_value0,
    output logic signed [23:0] o_value1,
    output logic signed [23:0] o_value2,
    output logic signed [23:0] o_value3,
    output logic        o_finished,
    output logic        o_last_of_tick
);
    import mclf_pkg::*;
    `include "multi_channel_linear_fade_engine_top_macros.svh"

    localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int KW = $clog2(JOB_SLOTS * MAX_CHANNELS);
    localparam int NW = $clog2(MAX_CHANNELS + 1);
    localparam int DEPTH = JOB_SLOTS * MAX_CHANNELS;

    t_state r_state, n_state;
    logic [JOB_SLOTS-1:0] r_active, r_paused;
    logic [NW-1:0] r_chans [JOB_SLOTS];

    // captured request
    logic [2:0]  r_act;
    logic [3:0]  r_job;
    logic [1:0]  r_chan;
    logic signed [31:0] r_st, r_tg;
    logic        r_lastc;
    logic        w_acc;

    // walk state
    logic [SW:0]   r_slot;
    logic [CW:0]   r_c;
    logic          r_done_all;
    logic          r_any;       // a result is pending in the held register
    logic signed [VALUE_W-1:0] r_vals [VALUE_FIELDS];
    logic [NW-1:0] r_cnt;

    // held register: one result waits here until the next one or the walk end
    logic [3:0]    r_oslot;
    logic [2:0]    r_ocnt;
    logic signed [VALUE_W-1:0] r_ov [VALUE_FIELDS];
    logic          r_ofin;

    // output register
    logic          r_oval;
    logic [3:0]    r_pslot;
    logic [2:0]    r_pcnt;
    logic signed [VALUE_W-1:0] r_pv [VALUE_FIELDS];
    logic          r_pfin, r_plast;

    // divider
    t_div_ctl w_dctl;
    logic signed [31:0] w_quot;

    // RAMs: current, goal, rate
    logic          w_we_cur, w_we_cfg;
    logic [KW-1:0] w_waddr, w_raddr;
    logic signed [31:0] w_cur_wd, w_cur_rd, w_goal_rd, w_rate_rd;

    logic w_job_ok, w_chan_ok, w_load_ok;
    logic [SW-1:0] w_slot_ix, w_job_ix;
    logic [CW-1:0] w_c_ix;
    logic w_slot_run, w_slot_end, w_ch_end;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_next;
    logic w_out_free, w_emit_mv, w_flush, w_push;

    assign w_acc     = i_valid && !o_stall;
    assign o_stall   = (r_state != ST_IDLE);
    assign w_slot_ix = r_slot[SW-1:0];
    assign w_job_ix  = SW'(r_job);
    assign w_c_ix    = r_c[CW-1:0];
    assign w_job_ok  = 32'(r_job) < JOB_SLOTS;
    assign w_chan_ok = 32'(r_chan) < MAX_CHANNELS;
    assign w_load_ok = (r_act == ACT_LOAD) && w_job_ok && w_chan_ok;
    assign w_slot_end = (32'(r_slot) >= JOB_SLOTS);
    assign w_slot_run = !w_slot_end && r_active[w_slot_ix] && !r_paused[w_slot_ix];
    assign w_ch_end  = (r_c >= (CW+1)'(r_cnt));
    assign w_out_free = !r_oval || !i_stall;
    // move the walked job into the held register; push the old one out
    assign w_emit_mv = (r_state == ST_EMIT) && (w_out_free || !r_any);
    // flush the held result as the tick's last once the walk ends
    assign w_flush   = (r_state == ST_SCAN) && w_slot_end && r_any && w_out_free;
    assign w_push    = w_flush || (w_emit_mv && r_any);

    // Shared step adder with clamp.
    assign w_sum = 33'(w_cur_rd) + 33'(w_rate_rd);
    always_comb begin
        if (w_rate_rd > 0 && w_cur_rd < w_goal_rd)
            w_next = (w_sum > 33'(w_goal_rd)) ? w_goal_rd : w_sum[31:0];
        else if (w_rate_rd < 0 && w_cur_rd > w_goal_rd)
            w_next = (w_sum < 33'(w_goal_rd)) ? w_goal_rd : w_sum[31:0];
        else
            w_next = w_goal_rd;
    end

    always_comb begin
        n_state  = r_state;
        w_we_cur = 1'b0;
        w_we_cfg = 1'b0;
        w_waddr  = KW'(w_job_ix * MAX_CHANNELS + w_c_ix);
        w_raddr  = KW'(w_slot_ix * MAX_CHANNELS + w_c_ix);
        w_cur_wd = w_next;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_action)
                        ACT_TICK: n_state = ST_SCAN;
                        ACT_LOAD: n_state = ST_DIV_RUN;
                        default:  n_state = ST_LOAD_WR;
                    endcase
                end
            end
            ST_DIV_RUN: if (w_dctl.done) n_state = ST_LOAD_WR;
            ST_LOAD_WR: begin
                w_waddr  = KW'(w_job_ix * MAX_CHANNELS + r_chan[CW-1:0]);
                w_we_cfg = w_load_ok;
                w_we_cur = w_load_ok;
                w_cur_wd = r_st;
                n_state  = ST_IDLE;
            end
            ST_SCAN: begin
                if (w_slot_end) begin
                    if (w_out_free) n_state = ST_IDLE;
                end else if (w_slot_run) n_state = ST_RD;
            end
            ST_RD: n_state = w_ch_end ? ST_EMIT : ST_RD_WAIT;
            ST_RD_WAIT: n_state = ST_STEP;
            ST_STEP: begin
                w_waddr  = KW'(w_slot_ix * MAX_CHANNELS + w_c_ix);
                w_we_cur = 1'b1;
                n_state  = ST_RD;
            end
            ST_EMIT: if (w_emit_mv) n_state = ST_SCAN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_paused <= '0;
            r_oval   <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_push) r_oval <= 1'b1;
            else if (!i_stall) r_oval <= 1'b0;
            if (w_acc || w_flush) r_any <= 1'b0;
            else if (w_emit_mv) r_any <= 1'b1;
            // stop, pause and resume apply in the write state
            if (r_state == ST_LOAD_WR && w_job_ok) begin
                unique case (r_act)
                    ACT_LOAD: if (w_chan_ok && r_lastc) begin
                        r_active[w_job_ix] <= 1'b1;
                        r_paused[w_job_ix] <= 1'b0;
                    end
                    ACT_STOP: begin
                        r_active[w_job_ix] <= 1'b0;
                        r_paused[w_job_ix] <= 1'b0;
                    end
                    ACT_PAUSE:  if (r_active[w_job_ix]) r_paused[w_job_ix] <= 1'b1;
                    ACT_RESUME: if (r_active[w_job_ix]) r_paused[w_job_ix] <= 1'b0;
                    default: ;
                endcase
            end
            // drop a finished job as it leaves the walk
            if (w_emit_mv && r_done_all) begin
                r_active[w_slot_ix] <= 1'b0;
                r_paused[w_slot_ix] <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_act   <= i_action;
            r_job   <= i_job;
            r_chan  <= i_channel;
            r_st    <= {i_start_value, 8'h00};
            r_tg    <= {i_target_value, 8'h00};
            r_lastc <= i_last_channel;
            r_slot  <= '0;
        end
        if (r_state == ST_LOAD_WR && w_load_ok && r_lastc)
            r_chans[w_job_ix] <= NW'(r_chan) + NW'(1);
        if (r_state == ST_SCAN && !w_slot_end) begin
            if (w_slot_run) begin
                r_c        <= '0;
                r_done_all <= 1'b1;
                r_cnt      <= r_chans[w_slot_ix];
                for (int j = 0; j < VALUE_FIELDS; j++) r_vals[j] <= '0;
            end else begin
                r_slot <= r_slot + (SW+1)'(1);
            end
        end
        if (r_state == ST_STEP) begin
            if (w_next != w_goal_rd) r_done_all <= 1'b0;
            for (int j = 0; j < VALUE_FIELDS; j++)
                if (32'(r_c) == j) r_vals[j] <= w_next[31:8];
            r_c <= r_c + (CW+1)'(1);
        end
        if (w_emit_mv) begin
            r_oslot <= 4'(w_slot_ix);
            r_ocnt  <= 3'(r_cnt);
            r_ofin  <= r_done_all;
            for (int j = 0; j < VALUE_FIELDS; j++) r_ov[j] <= r_vals[j];
            r_slot  <= r_slot + (SW+1)'(1);
        end
    end

    // Output register: advance from the held register only when free.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_pslot <= r_oslot;
            r_pcnt  <= r_ocnt;
            r_pfin  <= r_ofin;
            r_plast <= w_flush;
            for (int j = 0; j < VALUE_FIELDS; j++) r_pv[j] <= r_ov[j];
        end
    end

    assign o_valid         = r_oval;
    assign o_job_slot      = r_pslot;
    assign o_channel_count = r_pcnt;
    assign o_value0        = r_pv[0];
    assign o_value1        = r_pv[1];
    assign o_value2        = r_pv[2];
    assign o_value3        = r_pv[3];
    assign o_finished      = r_pfin;
    assign o_last_of_tick  = r_plast;

    mclf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc && i_action == ACT_LOAD),
        .i_num   (34'(signed'({i_target_value, 8'h00}))
                  - 34'(signed'({i_start_value, 8'h00}))),
        .i_den   (i_duration_ticks),
        .o_ctl   (w_dctl),
        .o_quot  (w_quot)
    );

    mclf_ram #(.WIDTH(LEVEL_W), .DEPTH(DEPTH)) u_cur (
        .i_clk(i_clk), .i_we(w_we_cur), .i_waddr(w_waddr), .i_wdata(w_cur_wd),
        .i_raddr(w_raddr), .o_rdata(w_cur_rd));
    mclf_ram #(.WIDTH(LEVEL_W), .DEPTH(DEPTH)) u_goal (
        .i_clk(i_clk), .i_we(w_we_cfg),
        .i_waddr(w_waddr), .i_wdata(r_tg), .i_raddr(w_raddr), .o_rdata(w_goal_rd));
    mclf_ram #(.WIDTH(LEVEL_W), .DEPTH(DEPTH)) u_rate (
        .i_clk(i_clk), .i_we(w_we_cfg),
        .i_waddr(w_waddr), .i_wdata(w_quot), .i_raddr(w_raddr), .o_rdata(w_rate_rd));

    `MCLF_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall, "busy")
    `MCLF_ASSERT_IMP(a_div_only_load, i_clk, i_rst_n, w_dctl.busy, r_state == ST_DIV_RUN, "div")
    `MCLF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_job_slot), "hold")
endmodule

// File: rtl/core/mclf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mclf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/mclf_div.sv
// Restoring signed divider: one quotient bit per cycle, saturated to 32 bits.
module mclf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [33:0]  i_num,
    input  logic [15:0]         i_den,
    output mclf_pkg::t_div_ctl  o_ctl,
    output logic signed [31:0]  o_quot
);
    import mclf_pkg::*;
    localparam int NW = 34;
    logic [NW-1:0] r_q, n_q;
    logic [16:0]   r_rem, n_rem;
    logic [15:0]   r_den;
    logic          r_neg;
    logic [5:0]    r_cnt;
    logic          r_busy, r_done;
    logic [16:0]   w_try;
    logic [NW-1:0] w_mag;
    logic signed [NW:0] w_sq;

    assign w_try = {r_rem[15:0], r_q[NW-1]} - {1'b0, r_den};
    always_comb begin
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = {r_rem[15:0], r_q[NW-1]};
        if (!w_try[16]) begin
            n_rem = w_try;
            n_q[0] = 1'b1;
        end
    end
    assign w_mag = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_den <= (i_den == '0) ? 16'd1 : i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end
    // Truncate toward zero, then saturate.
    assign w_sq = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    always_comb begin
        if (w_sq > (NW+1)'(signed'(32'h7FFF_FFFF))) o_quot = 32'sh7FFF_FFFF;
        else if (w_sq < -(NW+1)'(signed'({1'b0, 32'h8000_0000})))
            o_quot = 32'sh8000_0000;
        else o_quot = w_sq[31:0];
    end
    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
endmodule

// File: test/tb_multi_channel_linear_fade_engine_top.sv
// Self-checking testbench for the multi-channel linear fade engine.
`timescale 1ns / 1ps
module tb_multi_channel_linear_fade_engine_top;
    import mclf_pkg::*;

    localparam int SLOTS = 16;
    localparam int CHANS = 4;

    // One fade result as the engine reports it.
    typedef struct {
        logic [3:0]         slot;
        logic [2:0]         count;
        logic signed [23:0] val [4];
        logic               fin;
        logic               last;
    } t_fade_result;

    // One request row; typed expectations only hold for rows with chk set.
    typedef struct {
        t_action            act;
        logic [3:0]         job;
        logic [1:0]         chan;
        logic signed [23:0] start;
        logic signed [23:0] target;
        logic [15:0]        ticks;
        logic               last;
        bit                 chk;
        int                 n_exp;
    } t_fade_req;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_action = '0;
    logic [3:0]         i_job = '0;
    logic [1:0]         i_channel = '0;
    logic signed [23:0] i_start_value = '0;
    logic signed [23:0] i_target_value = '0;
    logic [15:0]        i_duration_ticks = '0;
    logic               i_last_channel = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [3:0]         o_job_slot;
    logic [2:0]         o_channel_count;
    logic signed [23:0] o_value0, o_value1, o_value2, o_value3;
    logic               o_finished;
    logic               o_last_of_tick;

    multi_channel_linear_fade_engine_top u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the engine's job table.
    logic              job_active [SLOTS];
    logic              job_paused [SLOTS];
    logic [2:0]        job_chans  [SLOTS];
    logic              chan_loaded [SLOTS][CHANS];
    logic signed [31:0] level_now  [SLOTS][CHANS];
    logic signed [31:0] level_goal [SLOTS][CHANS];
    logic signed [31:0] level_rate [SLOTS][CHANS];

    t_fade_result fade_results_due [$];
    int           errors = 0;
    int           pushed = 0;

    function automatic logic signed [31:0] step_level(logic signed [31:0] cur,
            logic signed [31:0] goal, logic signed [31:0] rate);
        logic signed [32:0] nxt;
        nxt = 33'(cur) + 33'(rate);
        if (rate > 0 && cur < goal) return (nxt > 33'(goal)) ? goal : nxt[31:0];
        if (rate < 0 && cur > goal) return (nxt < 33'(goal)) ? goal : nxt[31:0];
        return goal;
    endfunction

    // Apply one accepted request to the shadow table and queue its results.
    task automatic predict_fade(input t_fade_req rq);
        t_fade_result r;
        logic signed [40:0] st, tg, rt, dv;
        bit done;
        int lastidx;
        lastidx = -1;
        case (rq.act)
            ACT_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!job_active[s] || job_paused[s]) continue;
                    done = 1;
                    r.slot = 4'(s);
                    r.count = job_chans[s];
                    for (int c = 0; c < 4; c++) r.val[c] = '0;
                    for (int c = 0; c < job_chans[s]; c++) begin
                        level_now[s][c] = step_level(level_now[s][c], level_goal[s][c],
                                                     level_rate[s][c]);
                        if (level_now[s][c] != level_goal[s][c]) done = 0;
                        r.val[c] = level_now[s][c][31:8];
                    end
                    r.fin = done;
                    r.last = 0;
                    if (done) begin
                        job_active[s] = 0;
                        job_paused[s] = 0;
                    end
                    fade_results_due.push_back(r);
                    pushed++;
                    lastidx = fade_results_due.size() - 1;
                end
                if (lastidx >= 0) fade_results_due[lastidx].last = 1;
            end
            ACT_LOAD: begin
                st = 41'(rq.start) * 256;
                tg = 41'(rq.target) * 256;
                dv = (rq.ticks == 0) ? 41'sd1 : 41'(rq.ticks);
                rt = (tg - st) / dv;
                if (rt > 41'sh7FFFFFFF) rt = 41'sh7FFFFFFF;
                if (rt < -41'sh80000000) rt = -41'sh80000000;
                level_now[rq.job][rq.chan] = st[31:0];
                level_goal[rq.job][rq.chan] = tg[31:0];
                level_rate[rq.job][rq.chan] = rt[31:0];
                chan_loaded[rq.job][rq.chan] = 1;
                if (rq.last) begin
                    job_chans[rq.job] = 3'(rq.chan) + 3'd1;
                    job_active[rq.job] = 1;
                    job_paused[rq.job] = 0;
                end
            end
            ACT_STOP: begin
                job_active[rq.job] = 0;
                job_paused[rq.job] = 0;
            end
            ACT_PAUSE:  if (job_active[rq.job]) job_paused[rq.job] = 1;
            ACT_RESUME: if (job_active[rq.job]) job_paused[rq.job] = 0;
            default: ;
        endcase
    endtask

    // Drive one request, hold it through stalls, and predict on acceptance.
    task automatic send_request(input t_fade_req rq, input logic [2:0] raw_act);
        i_valid <= 1'b1;
        i_action <= raw_act;
        i_job <= rq.job;
        i_channel <= rq.chan;
        i_start_value <= rq.start;
        i_target_value <= rq.target;
        i_duration_ticks <= rq.ticks;
        i_last_channel <= rq.last;
        do @(posedge i_clk); while (o_stall);
        // unknown codes do nothing
        if (raw_act <= ACT_RESUME) predict_fade(rq);
    endtask

    // Random gap between bursts; one burst in three back to back.
    int burst_left = 0;
    task automatic maybe_gap();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    function automatic t_fade_req mk(t_action a, int j, int c, int s, int t, int n, bit l);
        t_fade_req rq;
        rq.act = a; rq.job = j; rq.chan = c; rq.start = s; rq.target = t;
        rq.ticks = n; rq.last = l; rq.chk = 0; rq.n_exp = 0;
        return rq;
    endfunction

    // Mark a row with a typed count of results.
    function automatic t_fade_req with_count(t_fade_req rq, int n);
        t_fade_req r;
        r = rq;
        r.chk = 1;
        r.n_exp = n;
        return r;
    endfunction

    // Fill the lower channels of a slot so no unwritten channel is ever read.
    task automatic load_job(input int j, input int nch, input bit extreme);
        int s, t;
        for (int c = 0; c < nch; c++) begin
            if (extreme) begin
                s = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
                t = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            end else begin
                s = $urandom;
                t = ($urandom_range(0, 3) == 0) ? s : $urandom;
            end
            maybe_gap();
            send_request(mk(ACT_LOAD, j, c, s, t,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 6),
                c == nch - 1), ACT_LOAD);
        end
    endtask

    // Result side: stall on a pattern of its own, check each taken result.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        t_fade_result e;
        logic signed [23:0] got [4];
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_value0, o_value1, o_value2, o_value3};
            if (fade_results_due.size() == 0) begin
                $display("%0t: unexpected result slot %0d", $time, o_job_slot);
                errors++;
            end else begin
                e = fade_results_due.pop_front();
                if (o_job_slot !== e.slot || o_channel_count !== e.count ||
                    o_finished !== e.fin || o_last_of_tick !== e.last) begin
                    $display("%0t: slot/count/fin/last exp %0d %0d %0b %0b got %0d %0d %0b %0b",
                        $time, e.slot, e.count, e.fin, e.last,
                        o_job_slot, o_channel_count, o_finished, o_last_of_tick);
                    errors++;
                end
                for (int c = 0; c < 4; c++)
                    if (got[c] !== e.val[c]) begin
                        $display("%0t: slot %0d value%0d exp %h got %h",
                            $time, e.slot, c, e.val[c], got[c]);
                        errors++;
                    end
            end
        end
        // Stall pattern: phases of none, periodic and random stalls.
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($time / 10) % 3 == 0;
            default: i_stall <= $urandom_range(0, 1);
        endcase
    end

    // Directed rows: reset-state, extremes, every action and special case.
    t_fade_req dir_rows [$];
    initial begin
        t_fade_req rq;
        int j;
        int before_n;
        for (int s = 0; s < SLOTS; s++) begin
            job_active[s] = 0; job_paused[s] = 0; job_chans[s] = 0;
            for (int c = 0; c < CHANS; c++) chan_loaded[s][c] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows = '{
            with_count(mk(ACT_TICK, 0, 0, 0, 0, 0, 0), 0),        // idle tick
            with_count(mk(ACT_PAUSE, 3, 0, 0, 0, 0, 0), 0),       // inactive slot
            mk(ACT_LOAD, 0, 0, 24'h800000, 24'h7FFFFF, 0, 1),     // rate overflow
            mk(ACT_LOAD, 15, 0, 24'h7FFFFF, 24'h800000, 0, 0),
            mk(ACT_LOAD, 15, 1, 24'h000100, 24'h000100, 1, 0),    // zero rate
            mk(ACT_LOAD, 15, 2, 0, 24'h000010, 65535, 0),
            mk(ACT_LOAD, 15, 3, 24'hFFFFFF, 24'h800000, 3, 1),    // four channels
            with_count(mk(ACT_TICK, 0, 0, 0, 0, 0, 0), 2),
            mk(ACT_PAUSE, 15, 0, 0, 0, 0, 0),
            mk(ACT_TICK, 0, 0, 0, 0, 0, 0),                       // paused skipped
            mk(ACT_RESUME, 15, 0, 0, 0, 0, 0),
            mk(ACT_LOAD, 15, 2, 24'h000010, 24'h000010, 2, 0),    // load into running
            mk(ACT_TICK, 0, 0, 0, 0, 0, 0),
            mk(ACT_LOAD, 7, 0, 24'h100000, 24'h000000, 4, 1),
            mk(ACT_LOAD, 7, 0, 24'h000000, 24'h100000, 4, 1),     // replace job
            mk(ACT_TICK, 0, 0, 0, 0, 0, 0),
            mk(ACT_STOP, 15, 0, 0, 0, 0, 0),
            mk(ACT_STOP, 7, 0, 0, 0, 0, 0),
            mk(ACT_RESUME, 7, 0, 0, 0, 0, 0),
            with_count(mk(ACT_TICK, 0, 0, 0, 0, 0, 0), 0)
        };
        foreach (dir_rows[i]) begin
            before_n = pushed;
            send_request(dir_rows[i], dir_rows[i].act);
            if (dir_rows[i].chk && pushed - before_n != dir_rows[i].n_exp) begin
                $display("%0t: row %0d result count exp %0d got %0d",
                    $time, i, dir_rows[i].n_exp, pushed - before_n);
                errors++;
            end
        end
        // Unknown action codes do nothing.
        for (int a = 5; a < 8; a++)
            send_request(mk(ACT_TICK, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom), 3'(a));

        // Random part: mostly well-formed loads followed by runs of ticks.
        for (int n = 0; n < 480; ) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    j = $urandom_range(0, SLOTS - 1);
                    load_job(j, $urandom_range(1, CHANS), $urandom_range(0, 7) == 0);
                    n += 3;
                end
                3: begin
                    // reload one already-written channel without starting
                    j = $urandom_range(0, SLOTS - 1);
                    if (chan_loaded[j][0]) begin
                        maybe_gap();
                        send_request(mk(ACT_LOAD, j, 0, $urandom, $urandom,
                                        $urandom_range(0, 9), 0), ACT_LOAD);
                        n++;
                    end
                end
                4: begin
                    maybe_gap();
                    rq = mk(t_action'($urandom_range(2, 4)), $urandom, 0, 0, 0, 0, 0);
                    send_request(rq, rq.act);
                    n++;
                end
                default: begin
                    maybe_gap();
                    send_request(mk(ACT_TICK, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom), ACT_TICK);
                    n++;
                end
            endcase
        end
        i_valid <= 1'b0;
        while (fade_results_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("multi_channel_linear_fade_engine_top regression: pass");
        else
            $display("multi_channel_linear_fade_engine_top regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #20ms;
        $display("multi_channel_linear_fade_engine_top regression: fail");
        $finish;
    end
endmodule
